// File: hdl/ycc_pkg.sv
package ycc_pkg;

  // Default geometry
  localparam int YCC_ANGLE_BITS = 16;
  localparam int YCC_SUM_BITS   = 40;

  // Fixed field widths
  localparam int FT_BITS       = 20;
  localparam int CNT_BITS      = 24;
  localparam int Q15_BITS      = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;

  // Register map
  localparam logic [CFG_IDX_BITS-1:0] REG_CALIBRATION_TIME = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FRAME_TIME   = CFG_IDX_BITS'(1);

  localparam logic [CNT_BITS-1:0] CAL_TIME_RESET  = CNT_BITS'(2000000);
  localparam logic [FT_BITS-1:0]  MAX_FRAME_RESET = FT_BITS'(100000);
  localparam logic [CNT_BITS-1:0] CNT_MAX         = {CNT_BITS{1'b1}};

  // CORDIC setup: angles carry 2^32 counts per turn, vectors are Q30
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam int ZW           = 34;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'sd2147483648);
  localparam int ONE_Q30_GAIN = 652032874;

  // Elementary rotation angles, atan(2^-i) in 2^32 counts per turn
  function automatic logic [31:0] arc_angle(input logic [STEP_BITS-1:0] idx);
    logic [31:0] a;
    case (idx)
      STEP_BITS'(0):  a = 32'd536870912;
      STEP_BITS'(1):  a = 32'd316933406;
      STEP_BITS'(2):  a = 32'd167458907;
      STEP_BITS'(3):  a = 32'd85004756;
      STEP_BITS'(4):  a = 32'd42667331;
      STEP_BITS'(5):  a = 32'd21354465;
      STEP_BITS'(6):  a = 32'd10679838;
      STEP_BITS'(7):  a = 32'd5340245;
      STEP_BITS'(8):  a = 32'd2670163;
      STEP_BITS'(9):  a = 32'd1335087;
      STEP_BITS'(10): a = 32'd667544;
      STEP_BITS'(11): a = 32'd333772;
      STEP_BITS'(12): a = 32'd166886;
      STEP_BITS'(13): a = 32'd83443;
      STEP_BITS'(14): a = 32'd41722;
      STEP_BITS'(15): a = 32'd20861;
      STEP_BITS'(16): a = 32'd10430;
      STEP_BITS'(17): a = 32'd5215;
      STEP_BITS'(18): a = 32'd2608;
      STEP_BITS'(19): a = 32'd1304;
      STEP_BITS'(20): a = 32'd652;
      STEP_BITS'(21): a = 32'd326;
      STEP_BITS'(22): a = 32'd163;
      STEP_BITS'(23): a = 32'd81;
      default:        a = 32'd0;
    endcase
    return a;
  endfunction

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTATE,
    S_ROUND,
    S_ACCUM,
    S_CHECK,
    S_VECTOR,
    S_ANGLE,
    S_EMIT
  } ycc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic step;
    logic round_q15;
    logic accumulate;
    logic vec_load;
    logic set_offset;
    logic emit;
  } ycc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic qualify;
    logic cordic_last;
    logic reached;
    logic out_free;
  } ycc_status_t;

endpackage

// File: hdl/ycc_in_if.sv
interface ycc_in_if
  import ycc_pkg::*;
#(
  parameter int ANGLE_BITS = YCC_ANGLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] head_yaw;
  logic signed [ANGLE_BITS-1:0] body_yaw;
  logic                         pose_valid;
  logic [FT_BITS-1:0]           frame_time_us;

  modport source (output valid, head_yaw, body_yaw, pose_valid, frame_time_us,
                  input ready);
  modport sink (input valid, head_yaw, body_yaw, pose_valid, frame_time_us,
                output ready);
endinterface

// File: hdl/ycc_out_if.sv
interface ycc_out_if
  import ycc_pkg::*;
#(
  parameter int ANGLE_BITS = YCC_ANGLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         calibrated;
  logic signed [ANGLE_BITS-1:0] center_offset;
  logic signed [ANGLE_BITS-1:0] centered_yaw;
  logic                         centered_valid;

  modport source (output valid, calibrated, center_offset, centered_yaw, centered_valid,
                  input ready);
  modport sink (input valid, calibrated, center_offset, centered_yaw, centered_valid,
                output ready);
endinterface

// File: hdl/ycc_cfg_if.sv
interface ycc_cfg_if
  import ycc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ycc_ctrl.sv
module ycc_ctrl
  import ycc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  ycc_status_t status,
  output ycc_cmd_t    cmd
);

  ycc_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = status.qualify ? S_ROTATE : S_EMIT;
        end
      end
      S_ROTATE: begin
        if (status.cordic_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: state_next = S_ACCUM;
      S_ACCUM: state_next = S_CHECK;
      S_CHECK: state_next = status.reached ? S_VECTOR : S_EMIT;
      S_VECTOR: begin
        if (status.cordic_last) begin
          state_next = S_ANGLE;
        end
      end
      S_ANGLE: state_next = S_EMIT;
      S_EMIT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
      end
      S_ROTATE: cmd.step = 1'b1;
      S_ROUND:  cmd.round_q15 = 1'b1;
      S_ACCUM:  cmd.accumulate = 1'b1;
      S_CHECK:  cmd.vec_load = status.reached;
      S_VECTOR: cmd.step = 1'b1;
      S_ANGLE:  cmd.set_offset = 1'b1;
      S_EMIT:   cmd.emit = status.out_free;
      default: begin
        cmd        = '0;
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/ycc_datapath.sv
module ycc_datapath
  import ycc_pkg::*;
#(
  parameter int ANGLE_BITS = YCC_ANGLE_BITS,
  parameter int SUM_BITS   = YCC_SUM_BITS
)(
  input  logic                         clk,
  input  logic                         rst,
  // incoming word
  input  logic signed [ANGLE_BITS-1:0] head_yaw,
  input  logic signed [ANGLE_BITS-1:0] body_yaw,
  input  logic                         pose_valid,
  input  logic [FT_BITS-1:0]           frame_time_us,
  // register writes
  input  logic                         cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  // result word
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         calibrated,
  output logic signed [ANGLE_BITS-1:0] center_offset,
  output logic signed [ANGLE_BITS-1:0] centered_yaw,
  output logic                         centered_valid,
  // control
  input  ycc_cmd_t                     cmd,
  output ycc_status_t                  status
);

  // CORDIC vector width covers the largest sum after negation plus gain growth
  localparam int CW = (SUM_BITS + 3 > 34) ? SUM_BITS + 3 : 34;
  localparam int FRAC_SHIFT = 32 - ANGLE_BITS;
  localparam logic signed [CW-1:0] Q15_HALF = CW'(16384);
  localparam logic signed [Q15_BITS-1:0] Q15_MAX = Q15_BITS'(32767);
  localparam logic signed [Q15_BITS-1:0] Q15_MIN = -Q15_BITS'(32767);
  localparam logic [31:0] ANGLE_ROUND = 32'(1) << (31 - ANGLE_BITS);

  // Configuration
  logic [CNT_BITS-1:0] cal_time;
  logic [FT_BITS-1:0]  max_frame;

  // Item and calibration state
  logic [ANGLE_BITS-1:0]      rel;
  logic                       pose_ok;
  logic [FT_BITS-1:0]         frame_time;
  logic signed [SUM_BITS-1:0] sine_sum;
  logic signed [SUM_BITS-1:0] cosine_sum;
  logic [CNT_BITS-1:0]        elapsed_us;
  logic                       is_calibrated;
  logic [ANGLE_BITS-1:0]      offset_angle;

  // Shared CORDIC
  logic signed [CW-1:0]  cx, cy;
  logic signed [ZW-1:0]  cz;
  logic                  neg_fix;
  logic                  vec_zero;
  logic                  vec_mode;
  logic [STEP_BITS-1:0]  step_cnt;
  logic signed [Q15_BITS-1:0] sin_q, cos_q;

  logic [ANGLE_BITS-1:0] rel_in;
  logic [31:0]           u_in;
  logic signed [ZW-1:0]  z_in, z_fold;
  logic                  neg_in;
  logic signed [CW-1:0]  dx, dy;
  logic signed [ZW-1:0]  arc;
  logic                  y_pos, ccw;
  logic signed [CW-1:0]  xs, ys;
  logic [CNT_BITS:0]     elapsed_wide;
  logic [31:0]           z_round;

  function automatic logic signed [Q15_BITS-1:0] round_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + Q15_HALF) >>> 15;
    if (t > CW'(Q15_MAX)) begin
      return Q15_MAX;
    end else if (t < CW'(Q15_MIN)) begin
      return Q15_MIN;
    end
    return t[Q15_BITS-1:0];
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a,
    input logic signed [Q15_BITS-1:0] b
  );
    logic signed [SUM_BITS:0] r;
    r = {a[SUM_BITS-1], a} + (SUM_BITS+1)'(b);
    if (r[SUM_BITS] != r[SUM_BITS-1]) begin
      return r[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return r[SUM_BITS-1:0];
  endfunction

  // Relative yaw and fold into the right half plane
  always_comb begin
    rel_in = ANGLE_BITS'(head_yaw - body_yaw);
    u_in   = {rel_in, {FRAC_SHIFT{1'b0}}};
    z_in   = ZW'($signed(u_in));
    neg_in = 1'b0;
    z_fold = z_in;
    if (z_in > Z_QUARTER) begin
      z_fold = z_in - Z_HALF;
      neg_in = 1'b1;
    end else if (z_in < -Z_QUARTER) begin
      z_fold = z_in + Z_HALF;
      neg_in = 1'b1;
    end
  end

  // One micro-rotation: x moves by shifted y, y by shifted x
  always_comb begin
    dx    = cy >>> step_cnt;
    dy    = cx >>> step_cnt;
    arc   = ZW'(arc_angle(step_cnt));
    y_pos = !cy[CW-1] && (cy != '0);
    ccw   = vec_mode ? !y_pos : !cz[ZW-1];
  end

  // Vectoring start from the sums
  always_comb begin
    xs = CW'(cosine_sum);
    ys = CW'(sine_sum);
  end

  assign elapsed_wide = {1'b0, elapsed_us} + (CNT_BITS+1)'(frame_time);
  assign z_round      = cz[31:0] + ANGLE_ROUND;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_time  <= CAL_TIME_RESET;
      max_frame <= MAX_FRAME_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CALIBRATION_TIME: cal_time  <= cfg_data[CNT_BITS-1:0];
        REG_MAX_FRAME_TIME:   max_frame <= cfg_data[FT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rel        <= rel_in;
      pose_ok    <= pose_valid;
      frame_time <= frame_time_us;
    end
  end

  // CORDIC registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      vec_mode <= 1'b0;
    end else if (cmd.load_item) begin
      step_cnt <= '0;
      vec_mode <= 1'b0;
    end else if (cmd.vec_load) begin
      step_cnt <= '0;
      vec_mode <= 1'b1;
    end else if (cmd.step && !status.cordic_last) begin
      step_cnt <= step_cnt + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cx      <= CW'(ONE_Q30_GAIN);
      cy      <= '0;
      cz      <= z_fold;
      neg_fix <= neg_in;
    end else if (cmd.vec_load) begin
      vec_zero <= (xs == '0) && (ys == '0);
      if (xs[CW-1]) begin
        cx <= -xs;
        cy <= -ys;
        cz <= Z_HALF;
      end else begin
        cx <= xs;
        cy <= ys;
        cz <= '0;
      end
    end else if (cmd.step) begin
      if (ccw) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - arc;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + arc;
      end
    end
  end

  // Q15 sine and cosine
  always_ff @(posedge clk) begin
    if (cmd.round_q15) begin
      sin_q <= round_q15(neg_fix ? -cy : cy);
      cos_q <= round_q15(neg_fix ? -cx : cx);
    end
  end

  // Calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      sine_sum      <= '0;
      cosine_sum    <= '0;
      elapsed_us    <= '0;
      is_calibrated <= 1'b0;
      offset_angle  <= '0;
    end else begin
      if (cmd.accumulate) begin
        sine_sum   <= sat_add(sine_sum, sin_q);
        cosine_sum <= sat_add(cosine_sum, cos_q);
        elapsed_us <= elapsed_wide[CNT_BITS] ? CNT_MAX : elapsed_wide[CNT_BITS-1:0];
      end
      if (cmd.set_offset) begin
        is_calibrated <= 1'b1;
        offset_angle  <= vec_zero ? '0 : z_round[31 -: ANGLE_BITS];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      calibrated     <= is_calibrated;
      center_offset  <= offset_angle;
      centered_yaw   <= rel - offset_angle;
      centered_valid <= is_calibrated && pose_ok;
    end
  end

  // Status
  always_comb begin
    status.qualify     = !is_calibrated && pose_valid && (frame_time_us != '0) &&
                         (frame_time_us <= max_frame);
    status.cordic_last = (step_cnt == STEP_BITS'(CORDIC_STEPS - 1));
    status.reached     = (elapsed_us >= cal_time);
    status.out_free    = !out_valid || out_ready;
  end

  // Checks
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    is_calibrated |=> is_calibrated)
    else $error("calibration flag dropped");

  a_offset_held: assert property (@(posedge clk) disable iff (rst)
    is_calibrated |=> $stable(offset_angle))
    else $error("offset changed after calibration");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_cnt < STEP_BITS'(CORDIC_STEPS))
    else $error("CORDIC step counter out of range");

  a_no_accum_calibrated: assert property (@(posedge clk) disable iff (rst)
    cmd.accumulate |-> !is_calibrated)
    else $error("accumulation after calibration");

endmodule

// File: hdl/yaw_center_calibration.sv
// Yaw center calibration. Each word on item carries head and body yaw (binary angles,
// 2^ANGLE_BITS counts per turn), a pose-valid flag and the frame time in microseconds;
// each yields exactly one word on result with the wrapped relative yaw minus the center
// offset. Until calibrated, a valid frame with 0 < frame_time_us <= max_frame_time_us
// adds the Q15 sine and cosine of the relative yaw to saturating sums and the frame time
// to a saturating elapsed total; when that total reaches calibration_time_us the offset
// is fixed to atan2 of the sums and held until reset. A frame that does not count goes
// from idle straight to the result register; a counted frame passes through 24 CORDIC
// rotation steps, rounding, accumulation and check; the frame that calibrates adds a
// second pass of 24 vectoring steps through the same CORDIC unit. One word is in work at a
// time; a finished result waits in an output register while the next word is taken.
// Registers: index 0 calibration_time_us, index 1 max_frame_time_us; writes to other
// indexes are dropped, cfg is always ready, and writes belong to idle periods.
module yaw_center_calibration
  import ycc_pkg::*;
#(
  parameter int ANGLE_BITS = YCC_ANGLE_BITS,
  parameter int SUM_BITS   = YCC_SUM_BITS
)(
  input logic       clk,
  input logic       rst,
  ycc_in_if.sink    item,
  ycc_out_if.source result,
  ycc_cfg_if.sink   cfg
);

  ycc_cmd_t    cmd;
  ycc_status_t status;
  logic        item_ready;

  assign item.ready = item_ready;
  assign cfg.ready  = 1'b1;

  // Sequencer
  ycc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Arithmetic and state
  ycc_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .head_yaw       (item.head_yaw),
    .body_yaw       (item.body_yaw),
    .pose_valid     (item.pose_valid),
    .frame_time_us  (item.frame_time_us),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .calibrated     (result.calibrated),
    .center_offset  (result.center_offset),
    .centered_yaw   (result.centered_yaw),
    .centered_valid (result.centered_valid),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
